// ===== src/spd_pkg.sv =====
// Shared constants and types for the sensor packet deframer.
`default_nettype none

package spd_pkg;

  // Frame format
  localparam int unsigned MAX_PAYLOAD    = 512;
  localparam int unsigned OVERHEAD_BYTES = 6;
  localparam logic [7:0]  SYNC_BYTE_1    = 8'hAA;
  localparam logic [7:0]  SYNC_BYTE_2    = 8'h55;

  // Field widths
  localparam int unsigned ADDR_W  = $clog2(MAX_PAYLOAD);
  localparam int unsigned LEN_W   = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned EVENT_W = 3;

  // Result queue depth
  localparam int unsigned OUT_DEPTH = 3;

  // Event codes
  typedef enum logic [EVENT_W-1:0] {
    EV_NONE     = 3'd0,
    EV_GOOD     = 3'd1,
    EV_BAD_TYPE = 3'd2,
    EV_BAD_LEN  = 3'd3,
    EV_BAD_SUM  = 3'd4,
    EV_TOO_LONG = 3'd5
  } event_t;

  // Request codes
  localparam logic REQ_STREAM = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Frame information carried with each request through the pipeline
  typedef struct packed {
    logic [EVENT_W-1:0] ev;
    logic [7:0]         ftype;
    logic [7:0]         fid;
    logic [LEN_W-1:0]   flen;
    logic               is_read;
  } meta_t;

  // One finished result
  typedef struct packed {
    meta_t      meta;
    logic [7:0] rdata;
  } result_t;

endpackage

`default_nettype wire

// ===== src/sensor_packet_deframer_unit.sv =====
// Sensor packet deframer: sync hunt, header checks, payload buffer, checksum.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  request  | in        | in_valid/in_stall  | req_type, rx_byte, read_index
//  result   | out       | out_valid/out_stall| event_res, frame_type, frame_id,
//           |           |                    |   frame_length, read_data
//  config   | in        | cfg_valid/cfg_ready| cfg_data (max_message_type)
//
// One request per cycle is accepted while in_stall is low; each result passes
// through the read stage (the payload buffer's registered read port), then the
// result queue. rst is synchronous; max_message_type resets to 255 and the
// payload buffer is not cleared. The three-entry result queue lets requests keep
// flowing while a result waits; in_stall rises only when the queue and the
// read stage together hold three results.
`default_nettype none

module sensor_packet_deframer_unit
  import spd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               req_type,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [8:0]         read_index,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [EVENT_W-1:0]      event_res,
  output logic [7:0]              frame_type,
  output logic [7:0]              frame_id,
  output logic [LEN_W-1:0]        frame_length,
  output logic [7:0]              read_data,
  // configuration channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data
);

  typedef enum logic [2:0] {
    ST_SYNC1 = 3'd0,
    ST_SYNC2 = 3'd1,
    ST_TYPE  = 3'd2,
    ST_ID    = 3'd3,
    ST_LEN   = 3'd4,
    ST_DATA  = 3'd5,
    ST_CSUM  = 3'd6
  } stage_t;

  localparam logic [15:0] OVERHEAD_16 = 16'(OVERHEAD_BYTES);
  localparam logic [15:0] MAX_16      = 16'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  // Parse state
  stage_t           stage, stage_next;
  logic [7:0]       type_reg, type_reg_next;
  logic [7:0]       id_reg, id_reg_next;
  logic [7:0]       low_byte_hold, low_byte_hold_next;
  logic             second_byte_flag, second_byte_flag_next;
  logic [LEN_W-1:0] payload_count, payload_count_next;
  logic [LEN_W-1:0] payload_target, payload_target_next;
  logic [15:0]      running_sum, running_sum_next;
  event_t           ev_next;
  logic             mem_we;

  logic [7:0]       max_message_type;

  // Payload buffer
  logic [7:0]       payload_store [MAX_PAYLOAD];
  logic [7:0]       rd_q;

  // Read stage
  logic             s1_valid;
  meta_t            s1_meta;

  // Result queue
  result_t          out_q [OUT_DEPTH];
  logic [1:0]       wr_ptr, rd_ptr, out_count;

  logic             accept, stream_acc, pop;
  logic [2:0]       occupancy;
  logic [15:0]      total_len, payload_len;
  logic [15:0]      sum_plus_byte;

  assign accept     = in_valid && !in_stall;
  assign stream_acc = accept && (req_type == REQ_STREAM);
  assign pop        = out_valid && !out_stall;
  assign occupancy  = {1'b0, out_count} + {2'b00, s1_valid};
  assign in_stall   = occupancy > 3'(OUT_DEPTH - 1);
  assign cfg_ready  = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_type <= 8'hFF;
    end else if (cfg_valid && cfg_ready) begin
      max_message_type <= cfg_data;
    end
  end

  // Per-byte parse
  assign total_len     = {rx_byte, low_byte_hold};
  assign payload_len   = total_len - OVERHEAD_16;
  assign sum_plus_byte = running_sum + {8'h00, rx_byte};

  always_comb begin
    stage_next            = stage;
    type_reg_next         = type_reg;
    id_reg_next           = id_reg;
    low_byte_hold_next    = low_byte_hold;
    second_byte_flag_next = second_byte_flag;
    payload_count_next    = payload_count;
    payload_target_next   = payload_target;
    running_sum_next      = running_sum;
    ev_next               = EV_NONE;
    mem_we                = 1'b0;
    unique case (stage)
      ST_SYNC1: begin
        if (rx_byte == SYNC_BYTE_1) begin
          type_reg_next         = '0;
          id_reg_next           = '0;
          low_byte_hold_next    = '0;
          second_byte_flag_next = 1'b0;
          payload_count_next    = '0;
          payload_target_next   = '0;
          running_sum_next      = '0;
          stage_next            = ST_SYNC2;
        end
      end
      ST_SYNC2: begin
        stage_next = (rx_byte == SYNC_BYTE_2) ? ST_TYPE : ST_SYNC1;
      end
      ST_TYPE: begin
        if (rx_byte > max_message_type) begin
          ev_next    = EV_BAD_TYPE;
          stage_next = ST_SYNC1;
        end else begin
          type_reg_next    = rx_byte;
          running_sum_next = {8'h00, rx_byte};
          stage_next       = ST_ID;
        end
      end
      ST_ID: begin
        id_reg_next      = rx_byte;
        running_sum_next = sum_plus_byte;
        stage_next       = ST_LEN;
      end
      ST_LEN: begin
        running_sum_next = sum_plus_byte;
        if (!second_byte_flag) begin
          low_byte_hold_next    = rx_byte;
          second_byte_flag_next = 1'b1;
        end else begin
          second_byte_flag_next = 1'b0;
          if (total_len < OVERHEAD_16) begin
            ev_next    = EV_BAD_LEN;
            stage_next = ST_SYNC1;
          end else if (payload_len > MAX_16) begin
            ev_next    = EV_TOO_LONG;
            stage_next = ST_SYNC1;
          end else begin
            payload_target_next = payload_len[LEN_W-1:0];
            payload_count_next  = '0;
            stage_next = (payload_len == 16'h0000) ? ST_CSUM : ST_DATA;
          end
        end
      end
      ST_DATA: begin
        mem_we             = payload_count < MAX_LEN;
        running_sum_next   = sum_plus_byte;
        payload_count_next = payload_count + 1'b1;
        if (payload_count_next >= payload_target) begin
          stage_next = ST_CSUM;
        end
      end
      ST_CSUM: begin
        if (!second_byte_flag) begin
          low_byte_hold_next    = rx_byte;
          second_byte_flag_next = 1'b1;
        end else begin
          second_byte_flag_next = 1'b0;
          ev_next    = (total_len == running_sum) ? EV_GOOD : EV_BAD_SUM;
          stage_next = ST_SYNC1;
        end
      end
      default: begin
        stage_next = ST_SYNC1;
      end
    endcase
  end

  // Parse state registers and read-stage record
  always_ff @(posedge clk) begin
    if (rst) begin
      stage            <= ST_SYNC1;
      type_reg         <= '0;
      id_reg           <= '0;
      low_byte_hold    <= '0;
      second_byte_flag <= 1'b0;
      payload_count    <= '0;
      payload_target   <= '0;
      running_sum      <= '0;
      s1_valid         <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (stream_acc) begin
        stage            <= stage_next;
        type_reg         <= type_reg_next;
        id_reg           <= id_reg_next;
        low_byte_hold    <= low_byte_hold_next;
        second_byte_flag <= second_byte_flag_next;
        payload_count    <= payload_count_next;
        payload_target   <= payload_target_next;
        running_sum      <= running_sum_next;
      end
    end
  end

  // Frame info as seen after this request
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta.is_read <= (req_type == REQ_READ);
      if (req_type == REQ_STREAM) begin
        s1_meta.ev    <= ev_next;
        s1_meta.ftype <= type_reg_next;
        s1_meta.fid   <= id_reg_next;
        s1_meta.flen  <= payload_target_next;
      end else begin
        s1_meta.ev    <= EV_NONE;
        s1_meta.ftype <= type_reg;
        s1_meta.fid   <= id_reg;
        s1_meta.flen  <= payload_target;
      end
    end
  end

  // Payload buffer: write on data bytes, registered read on read requests
  always_ff @(posedge clk) begin
    if (stream_acc && mem_we) begin
      payload_store[payload_count[ADDR_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req_type == REQ_READ)) begin
      rd_q <= payload_store[read_index[ADDR_W-1:0]];
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= (wr_ptr == 2'(OUT_DEPTH - 1)) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == 2'(OUT_DEPTH - 1)) ? 2'd0 : rd_ptr + 2'd1;
      end
      out_count <= out_count + {1'b0, s1_valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      out_q[wr_ptr].meta  <= s1_meta;
      out_q[wr_ptr].rdata <= s1_meta.is_read ? rd_q : 8'h00;
    end
  end

  // Output drive
  assign out_valid    = out_count != 2'd0;
  assign event_res    = out_q[rd_ptr].meta.ev;
  assign frame_type   = out_q[rd_ptr].meta.ftype;
  assign frame_id     = out_q[rd_ptr].meta.fid;
  assign frame_length = out_q[rd_ptr].meta.flen;
  assign read_data    = out_q[rd_ptr].rdata;

`ifndef NO_ASSERTIONS
  // Queue plus read stage never hold more than the queue can absorb
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    occupancy <= 3'(OUT_DEPTH))
    else $error("result queue overflow");

  // A read request never reports a frame event
  a_read_no_event: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_meta.is_read) |-> (s1_meta.ev == EV_NONE))
    else $error("read request carried an event");

  // Data stage always has bytes left to take
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (stage == ST_DATA) |-> (payload_count < payload_target))
    else $error("payload count reached target in data stage");

  // Any frame event sends the parser back to hunting
  a_event_hunt: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_meta.ev != EV_NONE)) |-> (stage == ST_SYNC1))
    else $error("event without return to sync hunt");

  // The payload target never exceeds the payload buffer size
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    payload_target <= MAX_LEN)
    else $error("payload target above buffer size");
`endif

endmodule

`default_nettype wire
